[hdl/klat_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klat_pkg
// Shared sizes, entry layout and outcome codes for the keyed ledger table.
// ----------------------------------------------------------------------------
package klat_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int OBJECT_BITS = 16;

  localparam int KIND_W   = 8;
  localparam int OBJ_IN_W = 16;
  localparam int VAL_W    = 32;
  localparam int PART_W   = 8;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;

  localparam int OBJ_USE_W = (OBJECT_BITS < OBJ_IN_W) ? OBJECT_BITS : OBJ_IN_W;
  localparam int KEY_W     = KIND_W + OBJECT_BITS;
  localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int MEM_DEPTH = 2 * (1 << IDX_W);

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 144;

  typedef enum logic [1:0] {
    OUT_MERGED   = 2'd0,
    OUT_APPENDED = 2'd1,
    OUT_REMOVED  = 2'd2,
    OUT_DROPPED  = 2'd3
  } outcome_e;

  typedef struct packed {
    logic [PART_W-1:0] partner;
    logic [VAL_W-1:0]  quantity;
    logic [VAL_W-1:0]  amount;
    logic [KEY_W-1:0]  key;
  } entry_t;

endpackage

[hdl/keyed_ledger_accumulate_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_ledger_accumulate_table
// Two keyed ledgers (income, expense) held in one synchronous table memory.
// Each item merges into a matching entry or appends one (dropped if the ledger
// is full); expense entries that reach zero are removed, the tail moves up.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                   | tuser
//  s_axis   | in  | kind, object, amount, quantity, partner | action
//  m_axis   | out | sums, slot, entry amount/qty, count     | outcome
//
//  One item at a time. The key scan reads one entry per cycle, and a removal
//  moves each later entry up one per cycle, so scan and move together visit
//  each entry once; an empty ledger skips the scan. tready returns with the
//  result. Reset clears totals, fill counts, control and result registers;
//  table contents are undefined until written. A stalled result waits in the
//  output register; the item behind it runs and then waits until the register
//  frees.
// ----------------------------------------------------------------------------
module keyed_ledger_accumulate_table
  import klat_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // txn_kind, object_key, amount, quantity, partner_id
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // action
  input  logic [0:0]            s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // income_sum, expense_sum, slot, entry_amount, entry_quantity, entry_count, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // outcome
  output logic [1:0]            m_axis_tuser_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_MERGE, ST_SHIFT, ST_APPEND, ST_RESULT
  } state_e;

  state_e state_q;

  logic             ledger_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] amt_q, qty_q;
  logic [PART_W-1:0] part_q;
  logic [CNT_W-1:0] n_q;
  logic [IDX_W-1:0] idx_q;
  logic [VAL_W-1:0] inc_total_q, exp_total_q;
  logic [CNT_W-1:0] used_q [2];

  logic [SLOT_W-1:0] res_slot_q;
  outcome_e          res_outcome_q;
  logic [VAL_W-1:0]  res_amt_q, res_qty_q;

  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic [1:0]            m_user_q;

  // table memory, address is {ledger, index}
  entry_t mem_q [MEM_DEPTH];
  entry_t rd_data_q;
  logic   rd_en, wr_en;
  logic   [IDX_W:0] rd_addr, wr_addr;
  entry_t wr_data;

  // input unpacking
  logic              in_action;
  logic [KIND_W-1:0] in_kind;
  logic [OBJ_IN_W-1:0] in_obj;
  logic [VAL_W-1:0]  in_amt, in_qty;
  logic [PART_W-1:0] in_part;
  logic [KEY_W-1:0]  in_key;
  logic              in_acc;

  assign in_action = s_axis_tuser_i[0];
  assign in_kind   = s_axis_tdata_i[7:0];
  assign in_obj    = s_axis_tdata_i[23:8];
  assign in_amt    = s_axis_tdata_i[55:24];
  assign in_qty    = s_axis_tdata_i[87:56];
  assign in_part   = s_axis_tdata_i[95:88];
  assign in_key    = {in_kind, OBJECT_BITS'(in_obj[OBJ_USE_W-1:0])};

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // scan and merge datapath
  logic             hit;
  logic [CNT_W-1:0] idx_ext, idx_nxt, idx_nxt2;
  logic [VAL_W-1:0] sum_amt, sum_qty;
  logic             gone;

  assign hit      = (rd_data_q.key == key_q);
  assign idx_ext  = CNT_W'(idx_q);
  assign idx_nxt  = idx_ext + CNT_W'(1);
  assign idx_nxt2 = idx_ext + CNT_W'(2);
  assign sum_amt  = rd_data_q.amount + amt_q;
  assign sum_qty  = rd_data_q.quantity + qty_q;
  assign gone     = ledger_q && (sum_amt == '0) && (sum_qty == '0);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {ledger_q, idx_q};
    wr_en   = 1'b0;
    wr_addr = {ledger_q, idx_q};
    wr_data = rd_data_q;
    unique case (state_q)
      ST_IDLE: begin
        rd_en   = in_acc && (used_q[in_action] != '0);
        rd_addr = {in_action, {IDX_W{1'b0}}};
      end
      ST_SCAN: begin
        rd_en   = !hit && (idx_nxt < n_q);
        rd_addr = {ledger_q, IDX_W'(idx_nxt)};
      end
      ST_MERGE: begin
        wr_en           = !gone;
        wr_data.amount   = sum_amt;
        wr_data.quantity = sum_qty;
        rd_en   = gone && (idx_nxt < n_q);
        rd_addr = {ledger_q, IDX_W'(idx_nxt)};
      end
      ST_SHIFT: begin
        // rd_data_q holds the entry after idx_q
        wr_en   = 1'b1;
        rd_en   = (idx_nxt2 < n_q);
        rd_addr = {ledger_q, IDX_W'(idx_nxt2)};
      end
      ST_APPEND: begin
        wr_en   = (n_q < CNT_W'(TABLE_DEPTH));
        wr_addr = {ledger_q, IDX_W'(n_q)};
        wr_data = '{partner: part_q, quantity: qty_q, amount: amt_q, key: key_q};
      end
      ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ledger_q      <= 1'b0;
      key_q         <= '0;
      amt_q         <= '0;
      qty_q         <= '0;
      part_q        <= '0;
      n_q           <= '0;
      idx_q         <= '0;
      inc_total_q   <= '0;
      exp_total_q   <= '0;
      used_q[0]     <= '0;
      used_q[1]     <= '0;
      res_slot_q    <= '0;
      res_outcome_q <= OUT_DROPPED;
      res_amt_q     <= '0;
      res_qty_q     <= '0;
      m_valid_q     <= 1'b0;
      m_data_q      <= '0;
      m_user_q      <= '0;
    end else begin
      // the result state refills the register itself
      if (m_valid_q && m_axis_tready_i && (state_q != ST_RESULT)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            ledger_q <= in_action;
            key_q    <= in_key;
            amt_q    <= in_amt;
            qty_q    <= in_qty;
            part_q   <= in_part;
            n_q      <= used_q[in_action];
            idx_q    <= '0;
            if (in_action) begin
              exp_total_q <= exp_total_q + in_amt;
            end else begin
              inc_total_q <= inc_total_q + in_amt;
            end
            state_q <= (used_q[in_action] == '0) ? ST_APPEND : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            state_q <= ST_MERGE;
          end else if (idx_nxt < n_q) begin
            idx_q <= IDX_W'(idx_nxt);
          end else begin
            state_q <= ST_APPEND;
          end
        end
        ST_MERGE: begin
          res_slot_q <= SLOT_W'(idx_q);
          res_amt_q  <= sum_amt;
          res_qty_q  <= sum_qty;
          if (gone) begin
            res_outcome_q    <= OUT_REMOVED;
            used_q[ledger_q] <= n_q - CNT_W'(1);
            state_q <= (idx_nxt < n_q) ? ST_SHIFT : ST_RESULT;
          end else begin
            res_outcome_q <= OUT_MERGED;
            state_q       <= ST_RESULT;
          end
        end
        ST_SHIFT: begin
          if (idx_nxt2 < n_q) begin
            idx_q <= IDX_W'(idx_nxt);
          end else begin
            state_q <= ST_RESULT;
          end
        end
        ST_APPEND: begin
          if (n_q < CNT_W'(TABLE_DEPTH)) begin
            res_outcome_q    <= OUT_APPENDED;
            res_slot_q       <= SLOT_W'(n_q);
            res_amt_q        <= amt_q;
            res_qty_q        <= qty_q;
            used_q[ledger_q] <= n_q + CNT_W'(1);
          end else begin
            res_outcome_q <= OUT_DROPPED;
            res_slot_q    <= '0;
            res_amt_q     <= '0;
            res_qty_q     <= '0;
          end
          state_q <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_user_q  <= res_outcome_q;
            m_data_q  <= {7'd0, COUNT_W'(used_q[ledger_q]), res_qty_q, res_amt_q,
                          res_slot_q, exp_total_q, inc_total_q};
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule
